[src/srsw_pkg.sv]
// Shared types, constants and codes of the selective repeat sender window.
// Used by the channel interfaces and by every module of the block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  localparam int WINDOW_SLOTS = 32;
  localparam int SEQ_BITS     = 16;
  localparam int SLOT_BITS    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  localparam int WIN_BITS     = 6;
  localparam int TOTAL_BITS   = 16;
  localparam int RETRY_BITS   = 6;
  localparam int TIMER_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Sends and resends allowed per word; completion always has room.
  localparam logic [RETRY_BITS-1:0] MAX_SENDS = 6'd33;

  localparam logic [WIN_BITS-1:0]   WINDOW_SIZE_RST   = 6'd20;
  localparam logic [TOTAL_BITS-1:0] TOTAL_PACKETS_RST = 16'd1;
  localparam logic [RETRY_BITS-1:0] MAX_RETRIES_RST   = 6'd30;
  localparam logic [TIMER_BITS-1:0] TIMEOUT_TICKS_RST = 16'd50;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ACK   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EVT_SEND     = 2'd0,
    EVT_RESEND   = 2'd1,
    EVT_COMPLETE = 2'd2
  } evt_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SIZE   = 2'd0,
    CFG_TOTAL_PACKETS = 2'd1,
    CFG_MAX_RETRIES   = 2'd2,
    CFG_TIMEOUT_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BASE,
    ST_SEND,
    ST_DONE,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    SOP_NONE,
    SOP_CLEAR,
    SOP_TICK,
    SOP_ACK,
    SOP_INIT
  } slot_op_e;

  // Effective register values, already clamped to legal ranges.
  typedef struct packed {
    logic [WIN_BITS-1:0]   win;
    logic [TOTAL_BITS-1:0] total;
    logic [RETRY_BITS-1:0] retry_lim;
    logic [TIMER_BITS-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    slot_op_e             op;
    logic [SLOT_BITS-1:0] idx;
  } slot_cmd_t;

  typedef struct packed {
    logic settled;
    logic fire;
    logic fin;
  } slot_view_t;

  typedef struct packed {
    evt_e                kind;
    logic [SEQ_BITS-1:0] seq;
    logic                fin;
  } result_t;

endpackage

`default_nettype wire

[src/srsw_if.sv]
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on srsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface srsw_in_if;
  logic                          valid;
  logic                          ready;
  srsw_pkg::cmd_e                command;
  logic [srsw_pkg::SEQ_BITS-1:0] ack_seq;
  logic                          ack_checksum_ok;

  modport source (output valid, output command, output ack_seq, output ack_checksum_ok,
                  input ready);
  modport sink   (input valid, input command, input ack_seq, input ack_checksum_ok,
                  output ready);
endinterface

interface srsw_out_if;
  logic                          valid;
  logic                          ready;
  srsw_pkg::evt_e                event_kind;
  logic [srsw_pkg::SEQ_BITS-1:0] packet_seq;
  logic                          final_attempt;
  logic                          last_of_run;

  modport source (output valid, output event_kind, output packet_seq,
                  output final_attempt, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input packet_seq,
                  input final_attempt, input last_of_run, output ready);
endinterface

interface srsw_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [srsw_pkg::CFG_IDX_BITS-1:0]  index;
  logic [srsw_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/srsw_cfg_regs.sv]
// Configuration registers of the sender window and their clamped values.
// Depends on srsw_pkg and srsw_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module srsw_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  srsw_cfg_if.sink      cfg,
  output srsw_pkg::cfg_t cfg_o
);

  logic [srsw_pkg::WIN_BITS-1:0]   win_q;
  logic [srsw_pkg::TOTAL_BITS-1:0] total_q;
  logic [srsw_pkg::RETRY_BITS-1:0] retry_q;
  logic [srsw_pkg::TIMER_BITS-1:0] timeout_q;
  srsw_pkg::cfg_idx_e              idx;

  assign cfg.ready = 1'b1;
  assign idx       = srsw_pkg::cfg_idx_e'(cfg.index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= srsw_pkg::WINDOW_SIZE_RST;
      total_q   <= srsw_pkg::TOTAL_PACKETS_RST;
      retry_q   <= srsw_pkg::MAX_RETRIES_RST;
      timeout_q <= srsw_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg.valid) begin
      unique case (idx)
        srsw_pkg::CFG_WINDOW_SIZE:   win_q     <= cfg.data[srsw_pkg::WIN_BITS-1:0];
        srsw_pkg::CFG_TOTAL_PACKETS: total_q   <= cfg.data[srsw_pkg::TOTAL_BITS-1:0];
        srsw_pkg::CFG_MAX_RETRIES:   retry_q   <= cfg.data[srsw_pkg::RETRY_BITS-1:0];
        srsw_pkg::CFG_TIMEOUT_TICKS: timeout_q <= cfg.data[srsw_pkg::TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o = '0;
    // A zero window behaves as one slot; anything beyond the slot count is capped.
    if (win_q == '0) begin
      cfg_o.win = srsw_pkg::WIN_BITS'(1);
    end else if (int'(win_q) > srsw_pkg::WINDOW_SLOTS) begin
      cfg_o.win = srsw_pkg::WIN_BITS'(srsw_pkg::WINDOW_SLOTS);
    end else begin
      cfg_o.win = win_q;
    end
    cfg_o.total     = total_q;
    cfg_o.retry_lim = (retry_q == '0) ? srsw_pkg::RETRY_BITS'(1) : retry_q;
    cfg_o.timeout   = (timeout_q == '0) ? srsw_pkg::TIMER_BITS'(1) : timeout_q;
  end

endmodule

`default_nettype wire

[src/srsw_slot_store.sv]
// Per-slot state (acked, given up, retry count, timer) and the shared
// timer/retry unit that works on one slot per cycle. Depends on srsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srsw_slot_store (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  srsw_pkg::cfg_t       cfg_i,
  input  srsw_pkg::slot_cmd_t  cmd_i,
  output srsw_pkg::slot_view_t view_o
);

  logic [srsw_pkg::WINDOW_SLOTS-1:0] acked_q, acked_d;
  logic [srsw_pkg::WINDOW_SLOTS-1:0] given_q, given_d;
  logic [srsw_pkg::RETRY_BITS-1:0]   retries_q [srsw_pkg::WINDOW_SLOTS];
  logic [srsw_pkg::TIMER_BITS-1:0]   timer_q   [srsw_pkg::WINDOW_SLOTS];

  logic [srsw_pkg::TIMER_BITS-1:0] timer_cur, timer_dec;
  logic [srsw_pkg::RETRY_BITS-1:0] retry_inc;
  logic                            expire;
  logic                            settled;

  // Shared unit: one countdown step and one retry compare for the addressed slot.
  always_comb begin
    timer_cur = timer_q[cmd_i.idx];
    timer_dec = (timer_cur != '0) ? timer_cur - srsw_pkg::TIMER_BITS'(1) : '0;
    expire    = (timer_dec == '0);
    retry_inc = retries_q[cmd_i.idx] + srsw_pkg::RETRY_BITS'(1);
    settled   = acked_q[cmd_i.idx] | given_q[cmd_i.idx];

    view_o.settled = settled;
    view_o.fire    = !settled && expire;
    view_o.fin     = (retry_inc >= cfg_i.retry_lim);
  end

  always_comb begin
    acked_d = acked_q;
    given_d = given_q;
    unique case (cmd_i.op)
      srsw_pkg::SOP_CLEAR: begin
        acked_d = '0;
        given_d = '0;
      end
      srsw_pkg::SOP_ACK:  acked_d[cmd_i.idx] = 1'b1;
      srsw_pkg::SOP_INIT: begin
        acked_d[cmd_i.idx] = 1'b0;
        given_d[cmd_i.idx] = 1'b0;
      end
      srsw_pkg::SOP_TICK: begin
        if (!settled && expire && view_o.fin) begin
          given_d[cmd_i.idx] = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q <= '0;
      given_q <= '0;
    end else begin
      acked_q <= acked_d;
      given_q <= given_d;
    end
  end

  // Counters and timers are always initialized by a new send before they are read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == srsw_pkg::SOP_INIT) begin
      retries_q[cmd_i.idx] <= '0;
      timer_q[cmd_i.idx]   <= cfg_i.timeout;
    end else if (cmd_i.op == srsw_pkg::SOP_TICK && !settled) begin
      if (expire) begin
        retries_q[cmd_i.idx] <= retry_inc;
        if (!view_o.fin) begin
          timer_q[cmd_i.idx] <= cfg_i.timeout;
        end
      end else begin
        timer_q[cmd_i.idx] <= timer_dec;
      end
    end
  end

endmodule

`default_nettype wire

[src/srsw_result_buf.sv]
// Result staging: one pending word whose last flag is still open, followed
// by the output register. Depends on srsw_pkg and srsw_out_if.
`timescale 1ns / 1ps
`default_nettype none

module srsw_result_buf (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  srsw_pkg::result_t push_data_i,
  input  wire logic        flush_i,
  output logic             can_accept_o,
  output logic             pend_valid_o,
  srsw_out_if.source       res
);

  logic              pend_v_q, pend_v_d;
  srsw_pkg::result_t pend_q, pend_d;
  logic              out_v_q, out_v_d;
  srsw_pkg::result_t out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_free;

  assign out_free     = !out_v_q || res.ready;
  assign can_accept_o = !pend_v_q || out_free;
  assign pend_valid_o = pend_v_q;

  // A word leaves the pending stage only when the next word or the end of the
  // run is known, which settles its last flag.
  always_comb begin
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !res.ready;
    out_d      = out_q;
    out_last_d = out_last_q;
    if (push_i) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_d      = pend_q;
        out_last_d = 1'b0;
      end
      pend_v_d = 1'b1;
      pend_d   = push_data_i;
    end else if (flush_i && pend_v_q) begin
      out_v_d    = 1'b1;
      out_d      = pend_q;
      out_last_d = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign res.valid         = out_v_q;
  assign res.event_kind    = out_q.kind;
  assign res.packet_seq    = out_q.seq;
  assign res.final_attempt = out_q.fin;
  assign res.last_of_run   = out_last_q;

endmodule

`default_nettype wire

[src/srsw_ctrl.sv]
// Sequencer of the sender window: on a tick scans the window one slot a cycle
// (waiting while a resend has no room), moves the base, sends new packets and reports completion.
// Depends on srsw_pkg and srsw_in_if.
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  srsw_in_if.sink               item,
  input  srsw_pkg::cfg_t        cfg_i,
  output srsw_pkg::slot_cmd_t   slot_cmd_o,
  input  srsw_pkg::slot_view_t  slot_view_i,
  output logic                  push_o,
  output srsw_pkg::result_t     push_data_o,
  output logic                  flush_o,
  input  wire logic             can_accept_i,
  input  wire logic             pend_valid_i
);

  localparam int SB = srsw_pkg::SEQ_BITS;

  srsw_pkg::state_e                state_q, state_d;
  logic [SB-1:0]                   base_q, base_d;
  logic [SB-1:0]                   next_q, next_d;
  logic [SB-1:0]                   scan_q, scan_d;
  logic [srsw_pkg::RETRY_BITS-1:0] sent_q, sent_d;
  logic                            run_q, run_d;
  logic [SB-1:0]                   in_flight;
  logic [SB-1:0]                   total_ext;

  assign in_flight = next_q - base_q;
  assign total_ext = SB'(cfg_i.total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsw_pkg::ST_IDLE;
      base_q  <= '0;
      next_q  <= '0;
      scan_q  <= '0;
      sent_q  <= '0;
      run_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      next_q  <= next_d;
      scan_q  <= scan_d;
      sent_q  <= sent_d;
      run_q   <= run_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    scan_d      = scan_q;
    sent_d      = sent_q;
    run_d       = run_q;
    item.ready  = 1'b0;
    slot_cmd_o  = '{op: srsw_pkg::SOP_NONE, idx: '0};
    push_o      = 1'b0;
    push_data_o = '{kind: srsw_pkg::EVT_SEND, seq: '0, fin: 1'b0};
    flush_o     = 1'b0;

    unique case (state_q)
      srsw_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          sent_d = '0;
          priority if (item.command == srsw_pkg::CMD_START) begin
            slot_cmd_o.op = srsw_pkg::SOP_CLEAR;
            base_d  = '0;
            next_d  = '0;
            run_d   = 1'b1;
            state_d = srsw_pkg::ST_SEND;
          end else if (item.command == srsw_pkg::CMD_RSVD || !run_q) begin
            state_d = srsw_pkg::ST_IDLE;
          end else if (item.command == srsw_pkg::CMD_TICK) begin
            scan_d  = base_q;
            state_d = srsw_pkg::ST_SCAN;
          end else begin
            if (item.ack_checksum_ok && item.ack_seq >= base_q && item.ack_seq < next_q) begin
              slot_cmd_o.op  = srsw_pkg::SOP_ACK;
              slot_cmd_o.idx = item.ack_seq[srsw_pkg::SLOT_BITS-1:0];
            end
            state_d = srsw_pkg::ST_BASE;
          end
        end
      end

      srsw_pkg::ST_SCAN: begin
        slot_cmd_o.idx = scan_q[srsw_pkg::SLOT_BITS-1:0];
        if (scan_q == next_q) begin
          state_d = srsw_pkg::ST_BASE;
        end else if (!slot_view_i.fire || can_accept_i) begin
          // A slot whose timer runs out is resent; the step waits for room.
          slot_cmd_o.op = srsw_pkg::SOP_TICK;
          scan_d        = scan_q + SB'(1);
          if (slot_view_i.fire) begin
            push_o      = 1'b1;
            push_data_o = '{kind: srsw_pkg::EVT_RESEND, seq: scan_q, fin: slot_view_i.fin};
            sent_d      = sent_q + srsw_pkg::RETRY_BITS'(1);
          end
        end
      end

      srsw_pkg::ST_BASE: begin
        slot_cmd_o.idx = base_q[srsw_pkg::SLOT_BITS-1:0];
        if (base_q != next_q && slot_view_i.settled) begin
          base_d = base_q + SB'(1);
        end else begin
          state_d = srsw_pkg::ST_SEND;
        end
      end

      srsw_pkg::ST_SEND: begin
        slot_cmd_o.idx = next_q[srsw_pkg::SLOT_BITS-1:0];
        if (next_q < total_ext && in_flight < SB'(cfg_i.win) &&
            sent_q < srsw_pkg::MAX_SENDS) begin
          if (can_accept_i) begin
            slot_cmd_o.op = srsw_pkg::SOP_INIT;
            push_o      = 1'b1;
            push_data_o = '{kind: srsw_pkg::EVT_SEND, seq: next_q, fin: 1'b0};
            next_d      = next_q + SB'(1);
            sent_d      = sent_q + srsw_pkg::RETRY_BITS'(1);
          end
        end else begin
          state_d = srsw_pkg::ST_DONE;
        end
      end

      srsw_pkg::ST_DONE: begin
        if (next_q >= total_ext && base_q == next_q) begin
          if (can_accept_i) begin
            push_o      = 1'b1;
            push_data_o = '{kind: srsw_pkg::EVT_COMPLETE, seq: '0, fin: 1'b0};
            run_d       = 1'b0;
            state_d     = srsw_pkg::ST_FLUSH;
          end
        end else begin
          state_d = srsw_pkg::ST_FLUSH;
        end
      end

      srsw_pkg::ST_FLUSH: begin
        if (!pend_valid_i) begin
          state_d = srsw_pkg::ST_IDLE;
        end else if (can_accept_i) begin
          flush_o = 1'b1;
          state_d = srsw_pkg::ST_IDLE;
        end
      end

      default: state_d = srsw_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[src/selective_repeat_sender_window.sv]
// Sender side of a selective repeat ARQ transfer.
// Channels: item_i takes command words (start, timer tick, acknowledgement);
// result_o gives send, resend and completion words, the last word caused by
// an input word flagged by last_of_run; cfg_i writes window_size (index 0),
// total_packets (1), max_retries (2) and timeout_ticks (3) and is always ready.
// One input word at a time: item_i is ready only while the sequencer is idle.
// An ignored word returns straight to idle. A start clears the window and then
// sends; an ack may mark its slot, moves the base and then sends; a tick scans
// the slots from base to next, resending those whose timer runs out, then moves
// the base and sends. Each of these words then passes a done and a flush state.
// Sends and resends per input word are at most 33. All loops go through the
// single slot store port, one slot a cycle while the result buffer has room.
// Each result waits in one pending stage until its last flag is known, and
// only then enters the output register. A stalled receiver holds the output
// register; the sequencer then waits on its next result, and a new word is
// still accepted while the final result of the previous one waits. Reset
// empties the window, stops any transfer and loads window_size 20,
// total_packets 1, max_retries 30 and timeout_ticks 50.
// Depends on srsw_pkg, the channel interfaces and the srsw_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srsw_cfg_if.sink   cfg_i,
  srsw_in_if.sink    item_i,
  srsw_out_if.source result_o
);

  srsw_pkg::cfg_t       cfg;
  srsw_pkg::slot_cmd_t  slot_cmd;
  srsw_pkg::slot_view_t slot_view;
  srsw_pkg::result_t    push_data;
  logic                 push;
  logic                 flush;
  logic                 can_accept;
  logic                 pend_valid;

  srsw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  srsw_slot_store u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (slot_cmd),
    .view_o (slot_view)
  );

  srsw_result_buf u_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .flush_i      (flush),
    .can_accept_o (can_accept),
    .pend_valid_o (pend_valid),
    .res          (result_o)
  );

  srsw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item         (item_i),
    .cfg_i        (cfg),
    .slot_cmd_o   (slot_cmd),
    .slot_view_i  (slot_view),
    .push_o       (push),
    .push_data_o  (push_data),
    .flush_o      (flush),
    .can_accept_i (can_accept),
    .pend_valid_i (pend_valid)
  );

endmodule

`default_nettype wire
